// ===== sv/mlfr_pkg.sv =====
// Package for the multichannel LED fade ramp.
// Holds the command, state-entry and status types and the fixed constants.
// Depends on nothing.
package mlfr_pkg;

	localparam int unsigned FULL_SCALE = 4095;
	localparam int unsigned LVL_W = 12;
	localparam int unsigned CUR_W = 28;
	localparam int unsigned RAMP_W = 16;
	localparam int unsigned NUM_W = 28;
	localparam int unsigned DIV_BITS = 44;
	localparam int unsigned DCNT_W = 6;

	typedef enum logic [1:0] {
		K_TARGET = 2'd0,
		K_CAP = 2'd1,
		K_RAMP = 2'd2,
		K_TICK = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [3:0] ch;
		logic [15:0] value;
		logic [NUM_W-1:0] num;
	} cmd_t;

	typedef struct packed {
		logic [LVL_W-1:0] tgt;
		logic [CUR_W-1:0] cur;
		logic [LVL_W-1:0] cap;
		logic [RAMP_W-1:0] ramp;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	localparam entry_t RESET_ENTRY = '{
		tgt: '0,
		cur: '0,
		cap: LVL_W'(FULL_SCALE),
		ramp: '0
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_EVAL,
		ST_WR,
		ST_DIV,
		ST_UPD,
		ST_MUL,
		ST_EMIT,
		ST_END
	} state_t;

	typedef struct packed {
		state_t state;
		logic pend_v;
		logic ramp_nz;
	} bk_status_t;

endpackage

// ===== sv/mlfr_if.sv =====
// Handshake interfaces for the fade ramp: command transactions in, level results out.
// Depends on nothing.
interface mlfr_cmd_if;
	logic valid;
	logic ready;
	logic [1:0] mode;
	logic [3:0] channel;
	logic [15:0] value;
	logic [15:0] elapsed_ms;
	modport source(output valid, mode, channel, value, elapsed_ms, input ready);
	modport sink(input valid, mode, channel, value, elapsed_ms, output ready);
endinterface

interface mlfr_res_if;
	logic valid;
	logic ready;
	logic [3:0] out_channel;
	logic [11:0] level;
	logic last;
	modport source(output valid, out_channel, level, last, input ready);
	modport sink(input valid, out_channel, level, last, output ready);
endinterface

// ===== sv/multichannel_led_fade_ramp.sv =====
// Top level of the multichannel LED fade ramp: front end, queue and back end.
// Depends on mlfr_pkg, mlfr_if, mlfr_front and mlfr_back.
//
// A command transaction sets one channel's target level, brightness cap or ramp time, or
// reports a tick of elapsed milliseconds. Commands are queued two deep and carried out one at
// a time. A target or ramp-time write returns no result, and a cap write returns one result.
// A tick sweeps every channel through the state RAM: a channel already at its target is
// skipped with no result, and a moving one with a nonzero ramp time waits on the 44-step
// serial divider that forms the step. Results leave through a one-entry output register;
// the last result of a tick carries last, and a cap write's single result does too.
module multichannel_led_fade_ramp #(
	parameter int CHANNELS = 16
) (
	input logic clk,
	input logic arst_n,
	mlfr_cmd_if.sink cmd,
	mlfr_res_if.source res
);
	logic pop;
	logic head_v;
	mlfr_pkg::cmd_t head;
	mlfr_pkg::bk_status_t bst;

	mlfr_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.pop(pop),
		.head_v(head_v),
		.head(head)
	);

	mlfr_back #(
		.CHANNELS(CHANNELS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_v(head_v),
		.head(head),
		.pop(pop),
		.res(res),
		.status(bst)
	);

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		bst.state == mlfr_pkg::ST_IDLE |-> !bst.pend_v)
		else $error("pending result left behind when back end went idle");

	a_not_last_has_successor: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.last |-> bst.pend_v)
		else $error("non-final result without a following result held");

	a_div_nonzero_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		bst.state == mlfr_pkg::ST_DIV |-> bst.ramp_nz)
		else $error("step divider running with zero ramp time");
endmodule

// ===== sv/mlfr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module mlfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== sv/mlfr_front.sv =====
// Front end: accepts command transactions, drops those that do nothing, and queues the rest.
// Depends on mlfr_pkg and mlfr_cmd_if.
module mlfr_front #(
	parameter int CHANNELS = 16
) (
	input logic clk,
	input logic arst_n,
	mlfr_cmd_if.sink cmd,
	input logic pop,
	output logic head_v,
	output mlfr_pkg::cmd_t head
);
	mlfr_pkg::cmd_t q_q [2];
	logic wp_q;
	logic rp_q;
	logic [1:0] cnt_q;
	logic keep;
	logic ch_ok;
	logic push;
	logic do_pop;
	mlfr_pkg::cmd_t entry;

	assign ch_ok = 32'(cmd.channel) < CHANNELS;

	always_comb begin
		entry.kind = mlfr_pkg::kind_t'(cmd.mode);
		entry.ch = cmd.channel;
		entry.value = cmd.value;
		entry.num = {16'b0, mlfr_pkg::LVL_W'(mlfr_pkg::FULL_SCALE)} * {12'b0, cmd.elapsed_ms};
		case (entry.kind)
			mlfr_pkg::K_TARGET, mlfr_pkg::K_CAP: begin
				keep = ch_ok && (32'(cmd.value) <= mlfr_pkg::FULL_SCALE);
			end
			mlfr_pkg::K_RAMP: begin
				keep = ch_ok;
			end
			default: begin
				keep = cmd.elapsed_ms != 16'd0;
			end
		endcase
	end

	assign cmd.ready = cnt_q != 2'd2;
	assign push = cmd.valid && cmd.ready && keep;
	assign head_v = cnt_q != 2'd0;
	assign head = q_q[rp_q];
	assign do_pop = pop && head_v;

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule

// ===== sv/mlfr_back.sv =====
// Back end: per-channel state in RAM, tick sweep with a serial step divider, capped levels out.
// Depends on mlfr_pkg, mlfr_res_if and mlfr_ram.
module mlfr_back #(
	parameter int CHANNELS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic head_v,
	input mlfr_pkg::cmd_t head,
	output logic pop,
	mlfr_res_if.source res,
	output mlfr_pkg::bk_status_t status
);
	localparam int CW = CHANNELS > 1 ? $clog2(CHANNELS) : 1;

	mlfr_pkg::state_t state_q;
	mlfr_pkg::state_t state_d;
	mlfr_pkg::cmd_t cmd_q;
	mlfr_pkg::entry_t ent_q;
	mlfr_pkg::entry_t eff;
	mlfr_pkg::entry_t rdata;
	mlfr_pkg::entry_t wdata;
	logic [CW-1:0] idx_q;
	logic [CHANNELS-1:0] valid_q;
	logic rd_vld_q;
	logic we;
	logic last_ch;
	logic [mlfr_pkg::DIV_BITS-1:0] n_q;
	logic [mlfr_pkg::DIV_BITS-1:0] q_q;
	logic [15:0] r_q;
	logic [mlfr_pkg::DCNT_W-1:0] cnt_q;
	logic [16:0] t;
	logic ge;
	logic [mlfr_pkg::CUR_W-1:0] tgt16;
	logic [mlfr_pkg::CUR_W-1:0] gap;
	logic [mlfr_pkg::CUR_W-1:0] new_cur;
	logic up;
	logic reach;
	logic [23:0] prod_q;
	logic [12:0] s;
	logic [11:0] lvl;
	logic [3:0] pend_ch_q;
	logic [11:0] pend_lvl_q;
	logic pend_v_q;
	logic o_v_q;
	logic [3:0] o_ch_q;
	logic [11:0] o_lvl_q;
	logic o_last_q;
	logic out_free;

	mlfr_ram #(
		.WIDTH(mlfr_pkg::ENTRY_W),
		.DEPTH(CHANNELS)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(idx_q),
		.wdata(wdata),
		.raddr(idx_q),
		.rdata(rdata)
	);

	assign eff = rd_vld_q ? rdata : mlfr_pkg::RESET_ENTRY;
	assign last_ch = idx_q == CW'(CHANNELS - 1);
	assign out_free = !o_v_q || res.ready;

	assign t = {r_q, n_q[mlfr_pkg::DIV_BITS-1]};
	assign ge = t >= {1'b0, ent_q.ramp};

	assign tgt16 = {ent_q.tgt, 16'b0};
	assign up = ent_q.cur < tgt16;
	assign gap = up ? tgt16 - ent_q.cur : ent_q.cur - tgt16;
	assign reach = (ent_q.ramp == '0) || (q_q >= mlfr_pkg::DIV_BITS'(gap));
	assign new_cur = reach ? tgt16 :
		(up ? ent_q.cur + q_q[mlfr_pkg::CUR_W-1:0] : ent_q.cur - q_q[mlfr_pkg::CUR_W-1:0]);

	// Division of the product by 4095: x = 4096a + b gives a + (a + b) / 4095, with a + b below 8190.
	assign s = {1'b0, prod_q[23:12]} + {1'b0, prod_q[11:0]};
	assign lvl = prod_q[23:12] + 12'(s >= 13'(mlfr_pkg::FULL_SCALE));

	always_comb begin
		state_d = state_q;
		case (state_q)
			mlfr_pkg::ST_IDLE: begin
				if (head_v) begin
					state_d = mlfr_pkg::ST_RD;
				end
			end
			mlfr_pkg::ST_RD: begin
				state_d = mlfr_pkg::ST_EVAL;
			end
			mlfr_pkg::ST_EVAL: begin
				if (cmd_q.kind != mlfr_pkg::K_TICK) begin
					state_d = mlfr_pkg::ST_WR;
				end else if (eff.cur == {eff.tgt, 16'b0}) begin
					state_d = last_ch ? mlfr_pkg::ST_END : mlfr_pkg::ST_RD;
				end else if (eff.ramp == '0) begin
					state_d = mlfr_pkg::ST_UPD;
				end else begin
					state_d = mlfr_pkg::ST_DIV;
				end
			end
			mlfr_pkg::ST_WR: begin
				state_d = (cmd_q.kind == mlfr_pkg::K_CAP) ? mlfr_pkg::ST_MUL : mlfr_pkg::ST_IDLE;
			end
			mlfr_pkg::ST_DIV: begin
				if (cnt_q == mlfr_pkg::DCNT_W'(mlfr_pkg::DIV_BITS - 1)) begin
					state_d = mlfr_pkg::ST_UPD;
				end
			end
			mlfr_pkg::ST_UPD: begin
				state_d = mlfr_pkg::ST_MUL;
			end
			mlfr_pkg::ST_MUL: begin
				state_d = mlfr_pkg::ST_EMIT;
			end
			mlfr_pkg::ST_EMIT: begin
				if (!pend_v_q || out_free) begin
					if (cmd_q.kind == mlfr_pkg::K_TICK && !last_ch) begin
						state_d = mlfr_pkg::ST_RD;
					end else begin
						state_d = mlfr_pkg::ST_END;
					end
				end
			end
			mlfr_pkg::ST_END: begin
				if (!pend_v_q || out_free) begin
					state_d = mlfr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mlfr_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		pop = 1'b0;
		we = 1'b0;
		wdata = ent_q;
		case (state_q)
			mlfr_pkg::ST_IDLE: begin
				pop = head_v;
			end
			mlfr_pkg::ST_WR: begin
				we = 1'b1;
				case (cmd_q.kind)
					mlfr_pkg::K_TARGET: wdata.tgt = cmd_q.value[11:0];
					mlfr_pkg::K_CAP: wdata.cap = cmd_q.value[11:0];
					default: wdata.ramp = cmd_q.value;
				endcase
			end
			mlfr_pkg::ST_UPD: begin
				we = 1'b1;
				wdata.cur = new_cur;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mlfr_pkg::ST_IDLE: begin
				cmd_q <= head;
			end
			mlfr_pkg::ST_EVAL: begin
				ent_q <= eff;
				n_q <= {cmd_q.num, 16'b0};
				q_q <= '0;
				r_q <= '0;
			end
			mlfr_pkg::ST_WR: begin
				ent_q <= wdata;
			end
			mlfr_pkg::ST_DIV: begin
				n_q <= {n_q[mlfr_pkg::DIV_BITS-2:0], 1'b0};
				q_q <= {q_q[mlfr_pkg::DIV_BITS-2:0], ge};
				r_q <= ge ? 16'(t - {1'b0, ent_q.ramp}) : t[15:0];
			end
			mlfr_pkg::ST_UPD: begin
				ent_q.cur <= new_cur;
			end
			mlfr_pkg::ST_MUL: begin
				prod_q <= ent_q.cur[mlfr_pkg::CUR_W-1:16] * ent_q.cap;
			end
			mlfr_pkg::ST_EMIT: begin
				if (!pend_v_q || out_free) begin
					pend_ch_q <= 4'(idx_q);
					pend_lvl_q <= lvl;
				end
			end
			default: begin
			end
		endcase
		if ((state_q == mlfr_pkg::ST_EMIT || state_q == mlfr_pkg::ST_END) && pend_v_q && out_free) begin
			o_ch_q <= pend_ch_q;
			o_lvl_q <= pend_lvl_q;
			o_last_q <= state_q == mlfr_pkg::ST_END;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlfr_pkg::ST_IDLE;
			idx_q <= '0;
			valid_q <= '0;
			rd_vld_q <= 1'b0;
			cnt_q <= '0;
			pend_v_q <= 1'b0;
			o_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_vld_q <= valid_q[idx_q];
			if (we) begin
				valid_q[idx_q] <= 1'b1;
			end
			if (state_q == mlfr_pkg::ST_IDLE && head_v) begin
				idx_q <= (head.kind == mlfr_pkg::K_TICK) ? '0 : CW'(head.ch);
			end else if (state_d == mlfr_pkg::ST_RD && state_q != mlfr_pkg::ST_IDLE) begin
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == mlfr_pkg::ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (state_q == mlfr_pkg::ST_EMIT && (!pend_v_q || out_free)) begin
				pend_v_q <= 1'b1;
			end else if (state_q == mlfr_pkg::ST_END && out_free) begin
				pend_v_q <= 1'b0;
			end
			if ((state_q == mlfr_pkg::ST_EMIT || state_q == mlfr_pkg::ST_END) && pend_v_q && out_free) begin
				o_v_q <= 1'b1;
			end else if (res.ready) begin
				o_v_q <= 1'b0;
			end
		end
	end

	assign res.valid = o_v_q;
	assign res.out_channel = o_ch_q;
	assign res.level = o_lvl_q;
	assign res.last = o_last_q;

	assign status.state = state_q;
	assign status.pend_v = pend_v_q;
	assign status.ramp_nz = ent_q.ramp != '0;
endmodule
